### rtl/scws_pkg.sv
package scws_pkg;

    // Table and window sizes (table size is a power of two)
    localparam int TABLE_ENTRIES = 256;
    localparam int WINDOW_SIZE   = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int WIN_W         = $clog2(WINDOW_SIZE);
    localparam int DATA_W        = 32;

    // Command codes
    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_DECAY  = 2'd1,
        CMD_WINDOW = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REC,
        ST_DEC,
        ST_DEC_END,
        ST_WIN,
        ST_DRAIN,
        ST_OUT,
        ST_ACK
    } t_state;

    // Input request
    typedef struct packed {
        logic [1:0]        command;
        logic [DATA_W-1:0] nonce;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [DATA_W-1:0] candidate;
        logic [DATA_W-1:0] candidate_score;
        logic              last_flag;
        logic              empty_flag;
    } t_out_item;

    // One slot of the sorting chain
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] cand;
        logic [DATA_W-1:0] score;
    } t_slot;

endpackage

### rtl/scored_candidate_window_sorter.sv
// From accept to first result valid: record reads then writes its entry, decay walks every
//   table entry (one table entry per cycle), window runs a read pass, then a chain settle,
//   then one result per cycle while the receiver is ready.
// Requests: one request at a time, taken again once the last result is loaded
//   and while it waits.
// Synchronous active-low reset: hit counts read zero, scores read one, limit all ones.
module scored_candidate_window_sorter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  scws_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output scws_pkg::t_out_item         o_out_data,
    input  logic                        i_cfg_we,
    input  logic [scws_pkg::DATA_W-1:0] i_cfg_data
);

    localparam int DW = scws_pkg::DATA_W;
    localparam int WS = scws_pkg::WINDOW_SIZE;

    scws_pkg::t_state r_state, n_state;

    logic [DW-1:0]              r_limit;
    logic [DW-1:0]              r_base,    n_base;
    logic                       r_wrap,    n_wrap;
    logic [scws_pkg::IDX_W-1:0] r_tab_idx, n_tab_idx;
    logic [scws_pkg::WIN_W-1:0] r_win_idx, n_win_idx;
    logic [scws_pkg::IDX_W-1:0] r_rd_addr, n_rd_addr;
    logic                       r_dec_wr,  n_dec_wr;
    logic                       r_feed_en, n_feed_en;
    logic [DW-1:0]              r_feed_cand, n_feed_cand;
    logic                       r_out_valid, n_out_valid;
    scws_pkg::t_out_item        r_out_data,  n_out_data;

    logic          w_accept;
    logic          w_out_free;
    logic [DW:0]   w_end_sum;
    logic [DW-1:0] w_win_cand;
    logic          w_we;
    logic [DW-1:0] w_wr_hits, w_wr_score;
    logic [DW-1:0] w_rd_hits, w_rd_score;
    logic [DW-1:0] w_rec_hits, w_rec_s7, w_rec_sum;
    logic [DW-1:0] w_dec_s, w_dec_h;
    logic          w_clear, w_shift;
    logic          w_head_last;

    scws_pkg::t_slot w_link [WS+1];
    scws_pkg::t_slot w_hold [WS+1];

    scws_pkg::t_out_item c_ack;

    assign c_ack = '{candidate: '0, candidate_score: '0, last_flag: 1'b1, empty_flag: 1'b1};

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_end_sum  = {1'b0, i_in_data.nonce} + (DW+1)'(WS);
    assign w_win_cand = r_base + DW'(r_win_idx);

    // Entry update arithmetic, all 32-bit wrapping
    assign w_rec_hits = w_rd_hits + DW'(1);
    assign w_rec_s7   = (w_rd_score << 3) - w_rd_score;
    assign w_rec_sum  = w_rec_s7 + (w_rec_hits << 8);
    assign w_dec_s    = (((w_rd_score << 8) - (w_rd_score << 2)) >> 8) + DW'(1);
    assign w_dec_h    = ((w_rd_hits << 8) - (w_rd_hits << 2)) >> 8;

    assign w_we       = (r_state == scws_pkg::ST_REC) || r_dec_wr;
    assign w_wr_hits  = (r_state == scws_pkg::ST_REC) ? w_rec_hits : w_dec_h;
    assign w_wr_score = (r_state == scws_pkg::ST_REC) ? (w_rec_sum >> 3) : w_dec_s;

    scws_tbl u_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (n_rd_addr),
        .i_we       (w_we),
        .i_wr_addr  (r_rd_addr),
        .i_wr_hits  (w_wr_hits),
        .i_wr_score (w_wr_score),
        .o_rd_hits  (w_rd_hits),
        .o_rd_score (w_rd_score)
    );

    // Sorting chain: head fed from the table read stage
    assign w_link[0]  = '{valid: r_feed_en, cand: r_feed_cand, score: w_rd_score};
    assign w_hold[WS] = '0;

    for (genvar g = 0; g < WS; g++) begin : g_cell
        scws_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (w_clear),
            .i_shift     (w_shift),
            .i_in        (w_link[g]),
            .i_next_hold (w_hold[g+1]),
            .o_hold      (w_hold[g]),
            .o_pass      (w_link[g+1])
        );
    end

    assign w_head_last = !w_hold[1].valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            scws_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.command)
                        scws_pkg::CMD_RECORD: n_state = scws_pkg::ST_REC;
                        scws_pkg::CMD_DECAY:  n_state = scws_pkg::ST_DEC;
                        scws_pkg::CMD_WINDOW: n_state = scws_pkg::ST_WIN;
                        default:              n_state = scws_pkg::ST_ACK;
                    endcase
                end
            end
            scws_pkg::ST_REC:     n_state = scws_pkg::ST_ACK;
            scws_pkg::ST_DEC: begin
                if (r_tab_idx == scws_pkg::IDX_W'(scws_pkg::TABLE_ENTRIES - 1)) begin
                    n_state = scws_pkg::ST_DEC_END;
                end
            end
            scws_pkg::ST_DEC_END: n_state = scws_pkg::ST_ACK;
            scws_pkg::ST_WIN: begin
                if (r_win_idx == scws_pkg::WIN_W'(WS - 1)) begin
                    n_state = scws_pkg::ST_DRAIN;
                end
            end
            scws_pkg::ST_DRAIN: begin
                if (r_win_idx == scws_pkg::WIN_W'(WS - 1)) begin
                    n_state = scws_pkg::ST_OUT;
                end
            end
            scws_pkg::ST_OUT: begin
                if (w_out_free && (!w_hold[0].valid || w_head_last)) begin
                    n_state = scws_pkg::ST_IDLE;
                end
            end
            scws_pkg::ST_ACK: begin
                if (w_out_free) begin
                    n_state = scws_pkg::ST_IDLE;
                end
            end
            default: n_state = scws_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls and next values
    always_comb begin
        n_base      = r_base;
        n_wrap      = r_wrap;
        n_tab_idx   = r_tab_idx;
        n_win_idx   = r_win_idx;
        n_rd_addr   = r_rd_addr;
        n_dec_wr    = 1'b0;
        n_feed_en   = 1'b0;
        n_feed_cand = w_win_cand;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        w_clear     = 1'b0;
        w_shift     = 1'b0;
        case (r_state)
            scws_pkg::ST_IDLE: begin
                n_rd_addr = i_in_data.nonce[scws_pkg::IDX_W-1:0];
                n_tab_idx = '0;
                n_win_idx = '0;
                if (w_accept) begin
                    n_base  = i_in_data.nonce;
                    n_wrap  = w_end_sum[DW];
                    w_clear = 1'b1;
                end
            end
            scws_pkg::ST_DEC: begin
                n_rd_addr = r_tab_idx;
                n_dec_wr  = 1'b1;
                n_tab_idx = r_tab_idx + scws_pkg::IDX_W'(1);
            end
            scws_pkg::ST_WIN: begin
                n_rd_addr = w_win_cand[scws_pkg::IDX_W-1:0];
                n_feed_en = !r_wrap && (w_win_cand < r_limit);
                n_win_idx = r_win_idx + scws_pkg::WIN_W'(1);
            end
            scws_pkg::ST_DRAIN: begin
                n_win_idx = r_win_idx + scws_pkg::WIN_W'(1);
            end
            scws_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (w_hold[0].valid) begin
                        n_out_data = '{candidate:       w_hold[0].cand,
                                       candidate_score: w_hold[0].score,
                                       last_flag:       w_head_last,
                                       empty_flag:      1'b0};
                        w_shift    = 1'b1;
                    end else begin
                        n_out_data = c_ack;
                    end
                end
            end
            scws_pkg::ST_ACK: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = c_ack;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scws_pkg::ST_IDLE;
            r_limit     <= '1;
            r_tab_idx   <= '0;
            r_win_idx   <= '0;
            r_dec_wr    <= 1'b0;
            r_feed_en   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tab_idx   <= n_tab_idx;
            r_win_idx   <= n_win_idx;
            r_dec_wr    <= n_dec_wr;
            r_feed_en   <= n_feed_en;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_wrap      <= n_wrap;
        r_rd_addr   <= n_rd_addr;
        r_feed_cand <= n_feed_cand;
        r_out_data  <= n_out_data;
    end

    assign o_in_ready  = (r_state == scws_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/scws_tbl.sv
module scws_tbl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [scws_pkg::IDX_W-1:0]  i_rd_addr,
    input  logic                        i_we,
    input  logic [scws_pkg::IDX_W-1:0]  i_wr_addr,
    input  logic [scws_pkg::DATA_W-1:0] i_wr_hits,
    input  logic [scws_pkg::DATA_W-1:0] i_wr_score,
    output logic [scws_pkg::DATA_W-1:0] o_rd_hits,
    output logic [scws_pkg::DATA_W-1:0] o_rd_score
);

    // Hit count in the upper half, score in the lower half
    logic [2*scws_pkg::DATA_W-1:0] r_mem [scws_pkg::TABLE_ENTRIES];
    logic [2*scws_pkg::DATA_W-1:0] r_rd_data;
    logic [scws_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic                          r_rd_valid;

    // Storage array: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= {i_wr_hits, i_wr_score};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Per-entry written flags; unwritten entries read as reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_hits  = r_rd_valid ? r_rd_data[2*scws_pkg::DATA_W-1:scws_pkg::DATA_W]
                                   : '0;
    assign o_rd_score = r_rd_valid ? r_rd_data[scws_pkg::DATA_W-1:0]
                                   : scws_pkg::DATA_W'(1);

endmodule

### rtl/scws_cell.sv
module scws_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_shift,
    input  scws_pkg::t_slot i_in,
    input  scws_pkg::t_slot i_next_hold,
    output scws_pkg::t_slot o_hold,
    output scws_pkg::t_slot o_pass
);

    scws_pkg::t_slot r_hold, n_hold;
    scws_pkg::t_slot r_pass, n_pass;

    // Insert: keep the larger score, hand the other on; on equal scores the
    // lower candidate number is kept so ties leave in ascending order
    always_comb begin
        n_hold = r_hold;
        n_pass = i_in;
        if (i_clear) begin
            n_hold.valid = 1'b0;
            n_pass.valid = 1'b0;
        end else if (i_shift) begin
            n_hold       = i_next_hold;
            n_pass.valid = 1'b0;
        end else if (i_in.valid) begin
            if (!r_hold.valid || (i_in.score > r_hold.score)
                || ((i_in.score == r_hold.score) && (i_in.cand < r_hold.cand))) begin
                n_hold = i_in;
                n_pass = r_hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold.valid <= 1'b0;
            r_pass.valid <= 1'b0;
        end else begin
            r_hold <= n_hold;
            r_pass <= n_pass;
        end
    end

    assign o_hold = r_hold;
    assign o_pass = r_pass;

endmodule
